// File: rtl/prefix_varint_decoder_macros.svh
// Assertion macros for the prefix varint decoder.
// Used by prefix_varint_decoder.sv; expects clk_i and rst_ni in scope.
`ifndef PREFIX_VARINT_DECODER_MACROS_SVH
`define PREFIX_VARINT_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PVD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PVD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pvd_pkg.sv
// Package for the prefix varint decoder: widths, length classes, prefix codes
// and the per-class byte count and mask tables. No dependencies.
`timescale 1ns / 1ps

package pvd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned LEFT_W  = 4;

  // Length classes of multi-byte integers
  typedef enum logic [2:0] {
    CLS_14  = 3'd0,
    CLS_21  = 3'd1,
    CLS_27  = 3'd2,
    CLS_35  = 3'd3,
    CLS_59  = 3'd4,
    CLS_40  = 3'd5,
    CLS_RAW = 3'd6
  } length_class_e;

  // Top five bits of first bytes for the narrow-range classes
  localparam logic [4:0] GRP_27 = 5'h1C;
  localparam logic [4:0] GRP_35 = 5'h1D;
  localparam logic [4:0] GRP_59 = 5'h1E;

  // Single prefix code of the 40-bit class and lowest reserved prefix code
  localparam logic [BYTE_W-1:0] PFX_40      = 8'hF8;
  localparam logic [BYTE_W-1:0] PFX_RSV_MIN = 8'hFA;

  // Bytes that follow the first byte
  function automatic logic [LEFT_W-1:0] class_extra(length_class_e cls);
    logic [LEFT_W-1:0] n;
    unique case (cls)
      CLS_14:  n = 4'd1;
      CLS_21:  n = 4'd2;
      CLS_27:  n = 4'd3;
      CLS_35:  n = 4'd4;
      CLS_59:  n = 4'd7;
      CLS_40:  n = 4'd5;
      CLS_RAW: n = 4'd8;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // Mask applied to the accumulated word at the last byte
  function automatic logic [VALUE_W-1:0] class_mask(length_class_e cls);
    logic [VALUE_W-1:0] m;
    unique case (cls)
      CLS_14:  m = 64'h0000_0000_0000_3FFF;
      CLS_21:  m = 64'h0000_0000_001F_FFFF;
      CLS_27:  m = 64'h0000_0000_07FF_FFFF;
      CLS_35:  m = 64'h0000_0007_FFFF_FFFF;
      CLS_59:  m = 64'h07FF_FFFF_FFFF_FFFF;
      CLS_40:  m = 64'h0000_00FF_FFFF_FFFF;
      CLS_RAW: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'h0000_0000_0000_3FFF;
    endcase
    return m;
  endfunction

  // Class chosen by a first byte in 0x80..0xF9
  function automatic length_class_e classify(logic [BYTE_W-1:0] b);
    length_class_e cls;
    if (!b[6]) begin
      cls = CLS_14;
    end else if (!b[5]) begin
      cls = CLS_21;
    end else begin
      unique case (b[7:3])
        GRP_27:  cls = CLS_27;
        GRP_35:  cls = CLS_35;
        GRP_59:  cls = CLS_59;
        default: cls = (b == PFX_40) ? CLS_40 : CLS_RAW;
      endcase
    end
    return cls;
  endfunction

endpackage

// File: rtl/pvd_if.sv
// Valid/ready channel interfaces for the prefix varint decoder.
// Depends on pvd_pkg for field widths.
`timescale 1ns / 1ps

// Input channel: one encoded byte per beat
interface pvd_byte_if
  import pvd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Output channel: one decoded integer per beat
interface pvd_result_if
  import pvd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] decoded_value;
  logic        [LEN_W-1:0]   encoded_length;
  logic                      reserved_prefix;

  modport source (output valid, output decoded_value, output encoded_length,
                  output reserved_prefix, input ready);
  modport sink   (input valid, input decoded_value, input encoded_length,
                  input reserved_prefix, output ready);
endinterface

// File: rtl/prefix_varint_decoder.sv
// Prefix varint decoder: an accepted byte goes through the input register, then
// the result register, to its result beat; one byte per cycle unless the output
// stalls. The byte-to-accumulator shift is one stage.
// Reset (rst_ni low, asynchronous) drops any partly received integer and
// empties both registers; the decoder then waits for a first byte.
// Depends on pvd_pkg, pvd_if.sv and prefix_varint_decoder_macros.svh.
`timescale 1ns / 1ps
`include "prefix_varint_decoder_macros.svh"

module prefix_varint_decoder
  import pvd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pvd_byte_if.sink     byte_i,
  pvd_result_if.source result_o
);

  // Input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;

  // Decoder state
  logic [VALUE_W-1:0] partial_q, partial_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  length_class_e      class_q, class_d;

  // Result register
  logic                out_valid_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [LEN_W-1:0]    out_len_q;
  logic                out_rsv_q;

  // Result of the current byte
  logic                res_valid;
  logic [VALUE_W-1:0]  res_value;
  logic [LEN_W-1:0]    res_len;
  logic                res_rsv;

  logic [VALUE_W-1:0]  acc;
  logic [LEFT_W-1:0]   left_dec;
  length_class_e       first_cls;

  logic out_free;
  logic step;

  // Handshake: result register frees when taken, input register when stepped
  assign out_free     = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && (!res_valid || out_free);
  assign byte_i.ready = !in_valid_q || step;

  assign acc       = {partial_q[VALUE_W-BYTE_W-1:0], in_byte_q};
  assign left_dec  = left_q - 4'd1;
  assign first_cls = classify(in_byte_q);

  // One decode step for the byte in the input register
  always_comb begin
    res_valid = 1'b0;
    res_value = '0;
    res_len   = 4'd1;
    res_rsv   = 1'b0;
    partial_d = partial_q;
    left_d    = left_q;
    class_d   = class_q;
    if (left_q == '0) begin
      if (!in_byte_q[BYTE_W-1]) begin
        // single-byte value
        res_valid = in_valid_q;
        res_value = {{(VALUE_W-BYTE_W){1'b0}}, in_byte_q};
      end else if (in_byte_q >= PFX_RSV_MIN) begin
        // reserved prefix: zero with flag
        res_valid = in_valid_q;
        res_rsv   = 1'b1;
      end else begin
        class_d   = first_cls;
        left_d    = class_extra(first_cls);
        partial_d = (first_cls == CLS_RAW) ? '0
                  : {{(VALUE_W-BYTE_W){1'b0}}, in_byte_q};
      end
    end else begin
      left_d    = left_dec;
      partial_d = acc;
      if (left_dec == '0) begin
        res_valid = in_valid_q;
        res_value = acc & class_mask(class_q);
        res_len   = class_extra(class_q) + 4'd1;
        partial_d = '0;
        class_d   = CLS_14;
      end
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= '0;
      class_q   <= CLS_14;
    end else if (step) begin
      partial_q <= partial_d;
      left_q    <= left_d;
      class_q   <= class_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_value_q <= res_value;
      out_len_q   <= res_len;
      out_rsv_q   <= res_rsv;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.decoded_value   = out_value_q;
  assign result_o.encoded_length  = out_len_q;
  assign result_o.reserved_prefix = out_rsv_q;

  // Checks
  `PVD_ASSERT_IMP(a_rsv_zero, out_valid_q && out_rsv_q,
    (out_value_q == '0) && (out_len_q == 4'd1), "reserved result not zero/one byte")
  `PVD_ASSERT_IMP(a_len_range, out_valid_q,
    (out_len_q >= 4'd1) && (out_len_q <= 4'd9), "encoded length out of range")
  `PVD_ASSERT_IMP(a_left_bound, left_q != '0,
    left_q <= class_extra(class_q), "bytes left exceeds class length")
  `PVD_ASSERT_NXT(a_stall_keeps_byte, in_valid_q && !step,
    in_valid_q && $stable(in_byte_q), "stalled input byte lost")

endmodule

// File: verif/tb.sv
// Testbench for prefix_varint_decoder: byte stream in, decoded integers out.
// A scoreboard predicts each integer from the accepted bytes and checks result beats.
// Depends on pvd_pkg, the channel interfaces in pvd_if.sv and the decoder RTL.
`timescale 1ns / 1ps

module tb
  import pvd_pkg::*;
();

  // One decoded integer as seen on the result channel
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
    logic               reserved;
  } decoded_int_t;

  // Tracks the integer being assembled and the integers still owed by the decoder
  class varint_scoreboard;
    logic [VALUE_W-1:0] acc;
    logic [LEFT_W-1:0]  remaining;
    length_class_e      cls;
    decoded_int_t       owed[$];
    int unsigned        mismatches;

    function new();
      acc        = '0;
      remaining  = '0;
      cls        = CLS_14;
      mismatches = 0;
    endfunction

    function automatic logic [LEFT_W-1:0] trailing_bytes(length_class_e c);
      case (c)
        CLS_14:  return 4'd1;
        CLS_21:  return 4'd2;
        CLS_27:  return 4'd3;
        CLS_35:  return 4'd4;
        CLS_59:  return 4'd7;
        CLS_40:  return 4'd5;
        default: return 4'd8;
      endcase
    endfunction

    function void owe(logic [VALUE_W-1:0] v, logic [LEN_W-1:0] n, logic r);
      decoded_int_t d;
      d.value    = v;
      d.length   = n;
      d.reserved = r;
      owed.insert(owed.size(), d);
    endfunction

    // Advance the decode by one accepted byte
    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned  bits;
      logic [VALUE_W-1:0] mask;
      if (remaining == 0) begin
        if (!b[7]) begin
          owe({56'd0, b}, 4'd1, 1'b0);
        end else if (b >= PFX_RSV_MIN) begin
          owe('0, 4'd1, 1'b1);
        end else begin
          if (b < 8'hC0)              cls = CLS_14;
          else if (b < 8'hE0)         cls = CLS_21;
          else if (b[7:3] == GRP_27)  cls = CLS_27;
          else if (b[7:3] == GRP_35)  cls = CLS_35;
          else if (b[7:3] == GRP_59)  cls = CLS_59;
          else if (b == PFX_40)       cls = CLS_40;
          else                        cls = CLS_RAW;
          remaining = trailing_bytes(cls);
          // raw form drops the prefix byte
          acc = (cls == CLS_RAW) ? '0 : {56'd0, b};
        end
      end else begin
        acc       = {acc[VALUE_W-BYTE_W-1:0], b};
        remaining = remaining - 4'd1;
        if (remaining == 0) begin
          case (cls)
            CLS_14:  bits = 14;
            CLS_21:  bits = 21;
            CLS_27:  bits = 27;
            CLS_35:  bits = 35;
            CLS_59:  bits = 59;
            CLS_40:  bits = 40;
            default: bits = 64;
          endcase
          mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
          owe(acc & mask, trailing_bytes(cls) + 4'd1, 1'b0);
          acc = '0;
          cls = CLS_14;
        end
      end
    endfunction

    function void flag(string what, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] MISMATCH %s: expected 0x%h, got 0x%h", $realtime, what, exp_v, act_v);
    endfunction

    // Compare one result beat against the oldest owed integer
    function void check_result(logic [VALUE_W-1:0] v, logic [LEN_W-1:0] n, logic r);
      decoded_int_t d;
      if (owed.size() == 0) begin
        flag("result beat with nothing owed (value)", '0, v);
        return;
      end
      d = owed.pop_front();
      if (v !== d.value)    flag("decoded_value", d.value, v);
      if (n !== d.length)   flag("encoded_length", {60'd0, d.length}, {60'd0, n});
      if (r !== d.reserved) flag("reserved_prefix", {63'd0, d.reserved}, {63'd0, r});
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pvd_byte_if   byte_if ();
  pvd_result_if res_if ();

  prefix_varint_decoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  varint_scoreboard sb = new();

  int unsigned bytes_sent = 0;
  int unsigned idle_pct   = 0;
  bit          quiet      = 1'b0;
  bit          hold_done  = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Known values on every block input from time zero
  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    res_if.ready      = 1'b0;
  end

  // Offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // One well-formed integer of a random class with random trailing bytes
  task automatic send_random_integer();
    int unsigned kind;
    int unsigned tail;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(0, 8);
    case (kind)
      0: begin first = 8'($urandom_range(8'h00, 8'h7F)); tail = 0; end
      1: begin first = 8'($urandom_range(8'h80, 8'hBF)); tail = 1; end
      2: begin first = 8'($urandom_range(8'hC0, 8'hDF)); tail = 2; end
      3: begin first = 8'($urandom_range(8'hE0, 8'hE7)); tail = 3; end
      4: begin first = 8'($urandom_range(8'hE8, 8'hEF)); tail = 4; end
      5: begin first = 8'($urandom_range(8'hF0, 8'hF7)); tail = 7; end
      6: begin first = PFX_40;                           tail = 5; end
      7: begin first = PFX_40 + 8'd1;                    tail = 8; end
      default: begin first = 8'($urandom_range(PFX_RSV_MIN, 8'hFF)); tail = 0; end
    endcase
    send_byte(first);
    repeat (tail) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  // Result acceptance; ready idles in short bursts plus one long hold-off
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= 250) begin
        // long hold-off so the decoder backs up into its input
        hold_done = 1'b1;
        stall = 59;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.decoded_value, res_if.encoded_length, res_if.reserved_prefix);
  end

  // Stimulus
  initial begin
    logic [BYTE_W-1:0] directed[$];
    directed = '{
      8'h00, 8'h7F, 8'hFA, 8'hFF,                          // one-byte forms
      8'h80, 8'hFF,                                        // 14-bit
      8'hDF, 8'h00, 8'hFF,                                 // 21-bit
      8'hE7, 8'hFF, 8'hFF, 8'hFF,                          // 27-bit
      8'hE8, 8'h00, 8'h00, 8'h00, 8'h01,                   // 35-bit
      8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, // 59-bit
      8'hF8, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h80,            // 40-bit
      8'hF9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, // raw, -1
      8'hF9, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00  // raw, most negative
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);

    // Random part in segments of differing idle density, calm at the end
    while (bytes_sent < 700) begin
      if (bytes_sent >= 600) begin
        quiet    = 1'b1;
        idle_pct = 0;
      end else if (bytes_sent % 100 < 10) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      send_random_integer();
    end

    // Stream cut short: a raw integer that never completes
    send_byte(PFX_40 + 8'd1);
    send_byte(8'h12);
    send_byte(8'h34);
    byte_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: prefix_varint_decoder.f
+incdir+rtl
rtl/pvd_pkg.sv
rtl/pvd_if.sv
rtl/prefix_varint_decoder.sv
verif/tb.sv
